@@ rtl/ppf_pkg.sv @@
// shared types, widths and register codes for the particle pair force block
`default_nettype none

package ppf_pkg;

    // field and datapath widths
    localparam int POS_W      = 16;
    localparam int SQ_W       = 34;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int NUM_W      = 49;
    localparam int DEN_W      = 44;
    localparam int QUO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_FRAC  = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTRACT_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPULSION    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COHESION     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_CUTOFF  = 3'd4;

    // register reset values
    localparam logic [15:0] RST_MIN_DIST     = 16'd253;
    localparam logic [15:0] RST_ATTRACT_DIST = 16'd518;
    localparam logic [15:0] RST_REPULSION    = 16'd16220;
    localparam logic [15:0] RST_COHESION     = 16'd405;
    localparam logic [31:0] RST_NEAR_CUTOFF  = 32'd655;

    typedef enum logic [1:0] {
        REGIME_NONE     = 2'd0,
        REGIME_REPEL    = 2'd1,
        REGIME_COHESION = 2'd2
    } regime_t;

    typedef struct packed {
        logic [POS_W-1:0] a_pos_x;
        logic [POS_W-1:0] a_pos_y;
        logic [POS_W-1:0] b_pos_x;
        logic [POS_W-1:0] b_pos_y;
    } in_t;

    typedef struct packed {
        logic signed [15:0] delta_vx;
        logic signed [15:0] delta_vy;
        regime_t            regime;
    } out_t;

endpackage

`default_nettype wire

@@ rtl/ppf_isqrt.sv @@
// pipelined integer square root, one root bit per stage
`default_nettype none

module ppf_isqrt import ppf_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   sq_in,
    output logic      [ROOT_W-1:0] root_out
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [REM_W-1:0]  rem_src  [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [ROOT_W-1:0] root_src  [ROOT_W];
    logic [SQ_W-1:0]   val_reg  [ROOT_W];
    logic [SQ_W-1:0]   val_next [ROOT_W];
    logic [SQ_W-1:0]   val_src  [ROOT_W];

    // stage inputs: first stage takes the square, the rest the stage before
    always_comb begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        val_src[0]  = sq_in;
        for (int k = 1; k < ROOT_W; k++) begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            val_src[k]  = val_reg[k-1];
        end
    end

    // one digit recurrence step per stage
    always_comb begin
        logic [REM_W-1:0] cand;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            cand  = {rem_src[k][REM_W-3:0], val_src[k][SQ_W-1 -: 2]};
            trial = {root_src[k], 2'b01};
            if (cand >= trial) begin
                rem_next[k]  = cand - trial;
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = cand;
                root_next[k] = {root_src[k][ROOT_W-2:0], 1'b0};
            end
            val_next[k] = {val_src[k][SQ_W-3:0], 2'b00};
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                val_reg[k]  <= val_next[k];
            end
        end
    end

    assign root_out = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

@@ rtl/ppf_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module ppf_div import ppf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num_in,
    input  wire logic [DEN_W-1:0] den_in,
    output logic      [QUO_W-1:0] quo_out
);

    localparam int CMP_W = DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg  [QUO_W];
    logic [NUM_W-1:0] rem_next [QUO_W];
    logic [NUM_W-1:0] rem_src  [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [DEN_W-1:0] den_src  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [QUO_W-1:0] quo_src  [QUO_W];

    // stage inputs
    always_comb begin
        rem_src[0] = num_in;
        den_src[0] = den_in;
        quo_src[0] = '0;
        for (int s = 1; s < QUO_W; s++) begin
            rem_src[s] = rem_reg[s-1];
            den_src[s] = den_reg[s-1];
            quo_src[s] = quo_reg[s-1];
        end
    end

    // compare and subtract the shifted divisor, msb first
    always_comb begin
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] rem_ext;
        for (int s = 0; s < QUO_W; s++) begin
            shifted = {{QUO_W{1'b0}}, den_src[s]} << (QUO_W - 1 - s);
            rem_ext = {{(CMP_W - NUM_W){1'b0}}, rem_src[s]};
            if (rem_ext >= shifted) begin
                rem_next[s] = NUM_W'(rem_ext - shifted);
                quo_next[s] = {quo_src[s][QUO_W-2:0], 1'b1};
            end else begin
                rem_next[s] = rem_src[s];
                quo_next[s] = {quo_src[s][QUO_W-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < QUO_W; s++) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_src[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo_out = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ rtl/particle_pair_force.sv @@
// top level: pairwise velocity change of two particles
// Usage: one request on s_valid/s_ready carries the positions of particles a
// and b (s_data); one result per request leaves on m_valid/m_ready (m_data)
// with the velocity change of a, saturated, and the interaction regime.
// Particle b takes the negation of the result.
// Registers are written on cfg_valid/cfg_ready (always ready) by index; the user
// must write them only while no request is in flight, which the block does not enforce.
// Path: a request passes 3 stages for offset and square (the first loads at
// the accepting edge), 17 stages of the square root (one root bit each),
// 5 stages for regime, gains, products and rounding bias, 16 stages per
// divider (one quotient bit each) and the output register.
// Throughput: one request per cycle while s_ready is high, set by the fully
// pipelined root and dividers; requests are independent.
// Reset: aresetn low clears all valid bits and loads the register defaults.
// Receiver stall: a waiting result holds in the output register, the next
// one goes into a skid register, and only when that is full does the whole
// pipeline freeze and s_ready drop; nothing is lost or repeated.
`default_nettype none

module particle_pair_force import ppf_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FRONT_N = 3;
    localparam int MID_N   = 5;
    localparam int STAGE_N = FRONT_N + ROOT_W + MID_N + QUO_W;

    typedef struct packed {
        logic [15:0] mx;
        logic [15:0] my;
        logic        xneg;
        logic        yneg;
        logic        skip;
    } root_sb_t;

    typedef struct packed {
        regime_t regime;
        logic    zero;
        logic    negx;
        logic    negy;
        logic    ovfx;
        logic    ovfy;
    } div_sb_t;

    // configuration registers
    logic [15:0] min_dist_reg;
    logic [15:0] attract_dist_reg;
    logic [15:0] repulsion_reg;
    logic [15:0] cohesion_reg;
    logic [31:0] near_cutoff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg     <= RST_MIN_DIST;
            attract_dist_reg <= RST_ATTRACT_DIST;
            repulsion_reg    <= RST_REPULSION;
            cohesion_reg     <= RST_COHESION;
            near_cutoff_reg  <= RST_NEAR_CUTOFF;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_DIST:     min_dist_reg     <= cfg_data[15:0];
                CFG_ATTRACT_DIST: attract_dist_reg <= cfg_data[15:0];
                CFG_REPULSION:    repulsion_reg    <= cfg_data[15:0];
                CFG_COHESION:     cohesion_reg     <= cfg_data[15:0];
                CFG_NEAR_CUTOFF:  near_cutoff_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable and valid bits
    logic pipe_en;
    logic skid_valid_reg;
    logic m_valid_reg;
    logic vld_reg [STAGE_N];

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGE_N; i++) vld_reg[i] <= 1'b0;
        end else if (pipe_en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < STAGE_N; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage a: offset magnitudes and signs
    logic [15:0] mx_a_reg, my_a_reg;
    logic        xneg_a_reg, yneg_a_reg;
    logic        xneg_a_next, yneg_a_next;
    logic [15:0] mx_a_next, my_a_next;

    always_comb begin
        xneg_a_next = s_data.a_pos_x < s_data.b_pos_x;
        yneg_a_next = s_data.a_pos_y < s_data.b_pos_y;
        mx_a_next = xneg_a_next ? s_data.b_pos_x - s_data.a_pos_x
                                : s_data.a_pos_x - s_data.b_pos_x;
        my_a_next = yneg_a_next ? s_data.b_pos_y - s_data.a_pos_y
                                : s_data.a_pos_y - s_data.b_pos_y;
    end

    // stage b: squares; stage c: squared length and cutoff
    logic [31:0]     sqx_b_reg, sqy_b_reg;
    root_sb_t        sb_b_reg;
    logic [SQ_W-1:0] d2_c_reg;
    root_sb_t        sb_c_reg;
    logic [SQ_W-1:0] d2_c_next;

    assign d2_c_next = {2'b00, sqx_b_reg} + {2'b00, sqy_b_reg};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mx_a_reg   <= mx_a_next;
            my_a_reg   <= my_a_next;
            xneg_a_reg <= xneg_a_next;
            yneg_a_reg <= yneg_a_next;
            sqx_b_reg  <= 32'(mx_a_reg) * 32'(mx_a_reg);
            sqy_b_reg  <= 32'(my_a_reg) * 32'(my_a_reg);
            sb_b_reg   <= '{mx: mx_a_reg, my: my_a_reg, xneg: xneg_a_reg,
                            yneg: yneg_a_reg, skip: 1'b0};
            d2_c_reg   <= d2_c_next;
            sb_c_reg   <= '{mx: sb_b_reg.mx, my: sb_b_reg.my, xneg: sb_b_reg.xneg,
                            yneg: sb_b_reg.yneg,
                            skip: d2_c_next < {2'b00, near_cutoff_reg}};
        end
    end

    // square root with its sideband delay line
    logic [ROOT_W-1:0] root;
    root_sb_t          rsb_reg [ROOT_W];

    ppf_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (pipe_en),
        .sq_in    (d2_c_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rsb_reg[0] <= sb_c_reg;
            for (int k = 1; k < ROOT_W; k++) rsb_reg[k] <= rsb_reg[k-1];
        end
    end

    // stage e: regime, distance span and gain select
    root_sb_t rsb;
    logic     rep_e, coh_e;
    regime_t  regime_e_next;
    logic [15:0] w_e_next, g_e_next, dist_e_next;
    logic     negx_e_next, negy_e_next, zero_e_next;

    assign rsb = rsb_reg[ROOT_W-1];

    always_comb begin
        rep_e = !rsb.skip && (root < {1'b0, min_dist_reg});
        coh_e = !rsb.skip && !rep_e && (root < {1'b0, attract_dist_reg});
        dist_e_next = root[15:0];
        priority if (rep_e) begin
            regime_e_next = REGIME_REPEL;
            w_e_next      = min_dist_reg - dist_e_next;
            g_e_next      = repulsion_reg;
            negx_e_next   = rsb.xneg;
            negy_e_next   = rsb.yneg;
        end else if (coh_e) begin
            regime_e_next = REGIME_COHESION;
            w_e_next      = attract_dist_reg - dist_e_next;
            g_e_next      = cohesion_reg;
            negx_e_next   = !rsb.xneg && (rsb.mx != 16'd0);
            negy_e_next   = !rsb.yneg && (rsb.my != 16'd0);
        end else begin
            regime_e_next = REGIME_NONE;
            w_e_next      = '0;
            g_e_next      = '0;
            negx_e_next   = 1'b0;
            negy_e_next   = 1'b0;
        end
        zero_e_next = !(rep_e || coh_e) || (root == '0);
    end

    regime_t     regime_e_reg, regime_f_reg, regime_g_reg, regime_h_reg, regime_i_reg;
    logic        zero_e_reg, zero_f_reg, zero_g_reg, zero_h_reg, zero_i_reg;
    logic        negx_e_reg, negx_f_reg, negx_g_reg, negx_h_reg, negx_i_reg;
    logic        negy_e_reg, negy_f_reg, negy_g_reg, negy_h_reg, negy_i_reg;
    logic [15:0] mx_e_reg, mx_f_reg, my_e_reg, my_f_reg;
    logic [15:0] w_e_reg, g_e_reg, dist_e_reg, span_e_reg;
    logic [31:0] f_f_reg, d_f_reg, d_g_reg;
    logic [47:0] numx_g_reg, numy_g_reg;
    logic [NUM_W-1:0] nx_h_reg, ny_h_reg, nx_i_reg, ny_i_reg;
    logic [DEN_W-1:0] den_h_reg, den_i_reg;
    logic        ovfx_i_reg, ovfy_i_reg;
    logic [NUM_W-1:0] bias_h;

    assign bias_h = {{(NUM_W - 32 - GAIN_FRAC + 1){1'b0}}, d_g_reg, {(GAIN_FRAC - 1){1'b0}}};

    // stages e to i: gain product, divisor, numerators, rounding, overflow
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            regime_e_reg <= regime_e_next;
            zero_e_reg   <= zero_e_next;
            negx_e_reg   <= negx_e_next;
            negy_e_reg   <= negy_e_next;
            mx_e_reg     <= rsb.mx;
            my_e_reg     <= rsb.my;
            w_e_reg      <= w_e_next;
            g_e_reg      <= g_e_next;
            dist_e_reg   <= dist_e_next;
            span_e_reg   <= attract_dist_reg - min_dist_reg;

            regime_f_reg <= regime_e_reg;
            zero_f_reg   <= zero_e_reg;
            negx_f_reg   <= negx_e_reg;
            negy_f_reg   <= negy_e_reg;
            mx_f_reg     <= mx_e_reg;
            my_f_reg     <= my_e_reg;
            f_f_reg      <= 32'(g_e_reg) * 32'(w_e_reg);
            d_f_reg      <= (regime_e_reg == REGIME_REPEL) ? {16'd0, dist_e_reg}
                                                            : 32'(dist_e_reg) * 32'(span_e_reg);

            regime_g_reg <= regime_f_reg;
            zero_g_reg   <= zero_f_reg;
            negx_g_reg   <= negx_f_reg;
            negy_g_reg   <= negy_f_reg;
            numx_g_reg   <= 48'(mx_f_reg) * 48'(f_f_reg);
            numy_g_reg   <= 48'(my_f_reg) * 48'(f_f_reg);
            d_g_reg      <= d_f_reg;

            regime_h_reg <= regime_g_reg;
            zero_h_reg   <= zero_g_reg;
            negx_h_reg   <= negx_g_reg;
            negy_h_reg   <= negy_g_reg;
            nx_h_reg     <= {1'b0, numx_g_reg} + bias_h;
            ny_h_reg     <= {1'b0, numy_g_reg} + bias_h;
            den_h_reg    <= {d_g_reg, {GAIN_FRAC{1'b0}}};

            regime_i_reg <= regime_h_reg;
            zero_i_reg   <= zero_h_reg;
            negx_i_reg   <= negx_h_reg;
            negy_i_reg   <= negy_h_reg;
            nx_i_reg     <= nx_h_reg;
            ny_i_reg     <= ny_h_reg;
            den_i_reg    <= den_h_reg;
            ovfx_i_reg   <= {{(DEN_W - NUM_W + QUO_W){1'b0}}, nx_h_reg[NUM_W-1:QUO_W]}
                            >= den_h_reg;
            ovfy_i_reg   <= {{(DEN_W - NUM_W + QUO_W){1'b0}}, ny_h_reg[NUM_W-1:QUO_W]}
                            >= den_h_reg;
        end
    end

    // dividers with their sideband delay line
    logic [QUO_W-1:0] qx, qy;
    div_sb_t          dsb_reg [QUO_W];

    ppf_div u_div_x (
        .aclk    (aclk),
        .en      (pipe_en),
        .num_in  (nx_i_reg),
        .den_in  (den_i_reg),
        .quo_out (qx)
    );

    ppf_div u_div_y (
        .aclk    (aclk),
        .en      (pipe_en),
        .num_in  (ny_i_reg),
        .den_in  (den_i_reg),
        .quo_out (qy)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dsb_reg[0] <= '{regime: regime_i_reg, zero: zero_i_reg, negx: negx_i_reg,
                            negy: negy_i_reg, ovfx: ovfx_i_reg, ovfy: ovfy_i_reg};
            for (int s = 1; s < QUO_W; s++) dsb_reg[s] <= dsb_reg[s-1];
        end
    end

    // sign and saturation of one component
    function automatic logic [15:0] sat_comp(input logic zero, input logic neg,
                                             input logic ovf, input logic [QUO_W-1:0] q);
        logic [16:0] mag;
        logic [15:0] res;
        mag = ovf ? 17'h10000 : {1'b0, q};
        if (zero) begin
            res = '0;
        end else if (!neg) begin
            res = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
        end else begin
            res = (mag > 17'd32768) ? 16'h8000 : 16'(17'h10000 - mag);
        end
        return res;
    endfunction

    div_sb_t dsb;
    out_t    res_next;
    logic    res_valid;

    assign dsb       = dsb_reg[QUO_W-1];
    assign res_valid = vld_reg[STAGE_N-1];

    always_comb begin
        res_next.delta_vx = sat_comp(dsb.zero, dsb.negx, dsb.ovfx, qx);
        res_next.delta_vy = sat_comp(dsb.zero, dsb.negy, dsb.ovfy, qy);
        res_next.regime   = dsb.regime;
    end

    // output register and skid register
    out_t m_data_reg, skid_data_reg;
    logic take_out, take_skid;

    always_comb begin
        take_out  = 1'b0;
        take_skid = 1'b0;
        if (!skid_valid_reg && res_valid) begin
            take_out  = !m_valid_reg || m_ready;
            take_skid = !take_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) m_valid_reg <= res_valid;
            if (take_skid) skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && m_ready) m_data_reg <= skid_data_reg;
        else if (take_out) m_data_reg <= res_next;
        if (take_skid) skid_data_reg <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/ppf_checker.sv @@
// port checker for the particle pair force block, with its bind
`default_nettype none

module ppf_checker import ppf_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // no code beyond cohesion
    a_regime_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.regime == REGIME_NONE || m_data.regime == REGIME_REPEL ||
                     m_data.regime == REGIME_COHESION))
        else $error("bad regime code");

    // a pair without interaction carries no velocity change
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.regime == REGIME_NONE |->
            m_data.delta_vx == 16'sd0 && m_data.delta_vy == 16'sd0)
        else $error("nonzero change without interaction");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result shown right after reset");

endmodule

bind particle_pair_force ppf_checker u_ppf_checker (.*);

`default_nettype wire

@@ tb/sv/particle_pair_force_tb.sv @@
// self-checking testbench for the particle pair force block
`timescale 1ns / 1ps
`default_nettype none

module particle_pair_force_tb;
    import ppf_pkg::*;

    localparam int LATENCY = 42;

    // register indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // directed stimulus row: positions plus an optional typed-in result
    typedef struct {
        logic [15:0] ax, ay, bx, by;
        bit          fixed;
        out_t        res;
    } pair_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [15:0] p_min_dist, p_attr_dist, p_rep_gain, p_coh_gain;
    logic [31:0] p_cutoff_sq;

    out_t force_queue[$];
    int   fail_count = 0;
    bit   sink_hold = 1'b0;
    bit   sink_quiet = 1'b0;
    bit   src_quiet = 1'b0;
    pair_row_t rows[$];

    particle_pair_force dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // integer square root by bit pairs
    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // rounded, signed, saturated velocity component
    function automatic logic [15:0] scaled_comp(input bit neg, input logic [127:0] num,
                                                input logic [127:0] den);
        logic [127:0] mag;
        mag = (num + den / 2) / den;
        if (!neg) begin
            if (mag > 32767) mag = 32767;
            return mag[15:0];
        end
        if (mag > 32768) mag = 32768;
        return 16'(17'h10000 - mag[16:0]);
    endfunction

    function automatic out_t pair_force(input in_t p);
        out_t o;
        bit xn, yn;
        logic [127:0] mx, my, d2, root_d, f, den;
        o = '0;
        o.regime = REGIME_NONE;
        xn = p.a_pos_x < p.b_pos_x;
        yn = p.a_pos_y < p.b_pos_y;
        mx = xn ? p.b_pos_x - p.a_pos_x : p.a_pos_x - p.b_pos_x;
        my = yn ? p.b_pos_y - p.a_pos_y : p.a_pos_y - p.b_pos_y;
        d2 = mx * mx + my * my;
        if (d2 < p_cutoff_sq) return o;
        root_d = 128'(root_of(d2[63:0]));
        if (root_d < p_min_dist) begin
            o.regime = REGIME_REPEL;
            if (root_d == 0) return o;
            f = p_rep_gain * (p_min_dist - root_d);
            den = root_d << GAIN_FRAC;
            o.delta_vx = scaled_comp(xn, mx * f, den);
            o.delta_vy = scaled_comp(yn, my * f, den);
        end else if (root_d < p_attr_dist) begin
            o.regime = REGIME_COHESION;
            // coincident particles have no direction
            if (root_d == 0) return o;
            f = p_coh_gain * (p_attr_dist - root_d);
            den = (root_d * (p_attr_dist - p_min_dist)) << GAIN_FRAC;
            o.delta_vx = scaled_comp(!xn && mx != 0, mx * f, den);
            o.delta_vy = scaled_comp(!yn && my != 0, my * f, den);
        end
        return o;
    endfunction

    task automatic cycles(input int n);
        repeat (n) @(posedge aclk);
    endtask

    // register write, taken on the cfg handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_MIN_DIST:     p_min_dist  = val[15:0];
            CFG_ATTRACT_DIST: p_attr_dist = val[15:0];
            CFG_REPULSION:    p_rep_gain  = val[15:0];
            CFG_COHESION:     p_coh_gain  = val[15:0];
            CFG_NEAR_CUTOFF:  p_cutoff_sq = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (force_queue.size() != 0) @(posedge aclk);
        cycles(LATENCY + 8);
    endtask

    // one request, with random gaps unless quiet
    task automatic send_pair(input in_t p, input bit fixed, input out_t res);
        int gap;
        gap = 0;
        while (!src_quiet && $urandom_range(99) < 21) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            cycles(gap);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        force_queue.insert(force_queue.size(), fixed ? res : pair_force(p));
    endtask

    function automatic logic [15:0] near_pos(input logic [15:0] c, input int span);
        int v;
        v = int'(c) + $urandom_range(2 * span) - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // random pair, mostly in the interaction range
    function automatic in_t random_pair();
        in_t p;
        int k;
        k = $urandom_range(9);
        p.a_pos_x = 16'($urandom);
        p.a_pos_y = 16'($urandom);
        if (k < 2) begin
            p.b_pos_x = 16'($urandom);
            p.b_pos_y = 16'($urandom);
        end else if (k < 6) begin
            p.b_pos_x = near_pos(p.a_pos_x, 300);
            p.b_pos_y = near_pos(p.a_pos_y, 300);
        end else begin
            p.b_pos_x = near_pos(p.a_pos_x, 700);
            p.b_pos_y = near_pos(p.a_pos_y, 700);
        end
        return p;
    endfunction

    // receiver with random stalls and a long hold-off
    always @(posedge aclk) begin
        if (!aresetn || sink_hold) m_ready <= 1'b0;
        else m_ready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 21);
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (force_queue.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_data);
                fail_count++;
            end else begin
                e = force_queue.pop_front();
                if (m_data.delta_vx !== e.delta_vx) begin
                    $display("%0t delta_vx expected %h actual %h", $time,
                             e.delta_vx, m_data.delta_vx);
                    fail_count++;
                end
                if (m_data.delta_vy !== e.delta_vy) begin
                    $display("%0t delta_vy expected %h actual %h", $time,
                             e.delta_vy, m_data.delta_vy);
                    fail_count++;
                end
                if (m_data.regime !== e.regime) begin
                    $display("%0t regime expected %0d actual %0d", $time,
                             e.regime, m_data.regime);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // random part: n random pairs under the current register settings
    task automatic random_phase(input int n);
        in_t  p;
        out_t z;
        z = '0;
        for (int i = 0; i < n; i++) begin
            p = random_pair();
            send_pair(p, 1'b0, z);
        end
    endtask

    initial begin
        pair_row_t r;
        in_t  p;
        out_t z;
        int   ok;
        z = '0;
        p_min_dist  = RST_MIN_DIST;
        p_attr_dist = RST_ATTRACT_DIST;
        p_rep_gain  = RST_REPULSION;
        p_coh_gain  = RST_COHESION;
        p_cutoff_sq = RST_NEAR_CUTOFF;
        cycles(4);
        aresetn <= 1'b1;
        cycles(2);

        // directed table, defaults
        rows.insert(rows.size(), '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
                                   '{16'sd0, 16'sd0, REGIME_NONE}});
        rows.insert(rows.size(), '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                   '{16'sd0, 16'sd0, REGIME_NONE}});
        rows.insert(rows.size(), '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1,
                                   '{16'sd0, 16'sd0, REGIME_NONE}});
        rows.insert(rows.size(), '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1,
                                   '{16'sd0, 16'sd0, REGIME_NONE}});
        rows.insert(rows.size(), '{16'd1000, 16'd1000, 16'd1010, 16'd1000, 1'b1,
                                   '{16'sd0, 16'sd0, REGIME_NONE}});
        rows.insert(rows.size(), '{16'd1100, 16'd1000, 16'd1000, 16'd1000, 1'b0, z});
        rows.insert(rows.size(), '{16'd1000, 16'd1000, 16'd1100, 16'd1000, 1'b0, z});
        rows.insert(rows.size(), '{16'd1000, 16'd1000, 16'd1000, 16'd1030, 1'b0, z});
        rows.insert(rows.size(), '{16'd1400, 16'd1000, 16'd1000, 16'd1000, 1'b0, z});
        rows.insert(rows.size(), '{16'd1000, 16'd1300, 16'd1000, 16'd1000, 1'b0, z});
        rows.insert(rows.size(), '{16'd1000, 16'd1000, 16'd1200, 16'd1200, 1'b0, z});
        rows.insert(rows.size(), '{16'd1000, 16'd1000, 16'd1253, 16'd1000, 1'b0, z});
        rows.insert(rows.size(), '{16'd1000, 16'd1000, 16'd1517, 16'd1000, 1'b0, z});
        rows.insert(rows.size(), '{16'd1518, 16'd1000, 16'd1000, 16'd1000, 1'b1,
                                   '{16'sd0, 16'sd0, REGIME_NONE}});
        rows.insert(rows.size(), '{16'd5000, 16'd5000, 16'd4990, 16'd4970, 1'b0, z});
        foreach (rows[i]) begin
            r = rows[i];
            p = '{r.ax, r.ay, r.bx, r.by};
            send_pair(p, r.fixed, r.res);
        end
        drain();

        // coincident particles with zero cutoff, saturating gain
        write_reg(CFG_NEAR_CUTOFF, 32'd0);
        write_reg(CFG_REPULSION, 32'hFFFF);
        send_pair('{16'd7, 16'd7, 16'd7, 16'd7}, 1'b1, '{16'sd0, 16'sd0, REGIME_REPEL});
        send_pair('{16'd8, 16'd7, 16'd7, 16'd7}, 1'b0, z);
        send_pair('{16'd7, 16'd6, 16'd7, 16'd7}, 1'b0, z);
        drain();
        // inverted distances and two unused indexes
        write_reg(CFG_ATTRACT_DIST, 32'd100);
        write_reg(CFG_UNUSED_LO, 32'hDEADBEEF);
        write_reg(CFG_UNUSED_HI, 32'h1);
        send_pair('{16'd300, 16'd300, 16'd600, 16'd300}, 1'b1,
                  '{16'sd0, 16'sd0, REGIME_NONE});
        send_pair('{16'd300, 16'd300, 16'd350, 16'd300}, 1'b0, z);
        drain();

        // random phases over several settings
        write_reg(CFG_MIN_DIST, 32'(RST_MIN_DIST));
        write_reg(CFG_ATTRACT_DIST, 32'(RST_ATTRACT_DIST));
        write_reg(CFG_REPULSION, 32'(RST_REPULSION));
        write_reg(CFG_COHESION, 32'(RST_COHESION));
        write_reg(CFG_NEAR_CUTOFF, RST_NEAR_CUTOFF);
        random_phase(200);

        // long receiver hold-off while requests keep coming
        sink_hold = 1'b1;
        fork
            begin
                cycles(150);
                sink_hold = 1'b0;
            end
            random_phase(80);
        join
        drain();

        write_reg(CFG_MIN_DIST, 32'hFFFF);
        write_reg(CFG_ATTRACT_DIST, 32'hFFFF);
        write_reg(CFG_REPULSION, 32'hFFFF);
        write_reg(CFG_COHESION, 32'hFFFF);
        write_reg(CFG_NEAR_CUTOFF, 32'hFFFF_FFFF);
        random_phase(60);
        drain();

        write_reg(CFG_NEAR_CUTOFF, 32'd0);
        write_reg(CFG_MIN_DIST, 32'd0);
        write_reg(CFG_ATTRACT_DIST, 32'd2000);
        write_reg(CFG_COHESION, 32'hFFFF);
        random_phase(120);
        drain();

        // quiet stretch with back-to-back traffic
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        write_reg(CFG_MIN_DIST, 32'd600);
        write_reg(CFG_ATTRACT_DIST, 32'd900);
        write_reg(CFG_REPULSION, 32'd0);
        write_reg(CFG_COHESION, 32'd4096);
        write_reg(CFG_NEAR_CUTOFF, 32'd1);
        random_phase(150);
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        drain();

        for (ok = 0; ok < 3; ok++) begin
            write_reg(CFG_MIN_DIST, 32'($urandom_range(1000)));
            write_reg(CFG_ATTRACT_DIST, 32'($urandom_range(1500)));
            write_reg(CFG_REPULSION, 32'($urandom_range(65535)));
            write_reg(CFG_COHESION, 32'($urandom_range(65535)));
            write_reg(CFG_NEAR_CUTOFF, 32'($urandom_range(20000)));
            random_phase(80);
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
